// ===== rtl/core/vgp_pkg.sv =====
// Shared constants, types and register codes for the vignette and grain pixel post stage.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package vgp_pkg;

	localparam int MAX_DIM      = 4096;
	localparam int CHANNEL_BITS = 12;
	localparam int DIM_W        = 13;
	localparam int RECIP_W      = 25;
	localparam int DIV_STEPS    = RECIP_W;
	localparam int SQ_STAGES    = 9;
	localparam int SQ_STEPS     = 2;
	localparam int RAD_W        = 36;
	localparam int ROOT_W       = 18;

	localparam logic [12:0] DIM_MAX    = 13'(MAX_DIM);
	localparam logic [11:0] CH_FULL    = 12'((1 << CHANNEL_BITS) - 1);
	localparam logic [28:0] CH_RECIP   = 29'((64'd1 << 40) / 64'(CH_FULL));
	localparam logic [16:0] Q16_ONE    = 17'd65536;
	localparam logic [17:0] COORD_SAT  = 18'd131072;
	localparam logic [15:0] ELLIPSE_K  = 16'd51118;
	localparam logic [17:0] EDGE_LO    = 18'd22938;
	localparam logic [17:0] EDGE_HI    = 18'd95027;
	localparam logic [16:0] SPAN       = 17'd72089;
	localparam logic [31:0] SPAN_RECIP = 32'((64'd1 << 48) / 64'd72089);

	localparam logic [31:0] HASH_KX    = 32'd73856093;
	localparam logic [31:0] HASH_KY    = 32'd19349663;
	localparam logic [31:0] HASH_KS    = 32'd83492791;
	localparam logic [31:0] HASH_KM    = 32'd1274126177;
	localparam logic [31:0] NOISE_SEED = 32'd1337;
	localparam logic [31:0] NOISE_MIX  = 32'(64'(NOISE_SEED) * 64'(HASH_KS));
	localparam logic [23:0] NOISE_FULL = 24'hFFFFFF;

	localparam logic [7:0]  STRENGTH_RST = 8'd115;
	localparam logic [7:0]  GRAIN_RST    = 8'd13;
	localparam logic [12:0] WIDTH_RST    = 13'd1920;
	localparam logic [12:0] HEIGHT_RST   = 13'd1080;
	localparam logic [24:0] RECIP_NUM    = 25'(64'd1 << 24);
	localparam logic [24:0] RECIP_X_RST  =
		25'(((64'd1 << 24) + 64'(WIDTH_RST) / 2) / 64'(WIDTH_RST));
	localparam logic [24:0] RECIP_Y_RST  =
		25'(((64'd1 << 24) + 64'(HEIGHT_RST) / 2) / 64'(HEIGHT_RST));

	typedef enum logic [1:0] {
		REG_STRENGTH = 2'd0,
		REG_GRAIN    = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  strength;
		logic [7:0]  grain;
		logic [12:0] dim_x;
		logic [12:0] dim_y;
		logic [24:0] recip_x;
		logic [24:0] recip_y;
		logic        busy;
	} vgp_cfg_t;

	typedef struct packed {
		logic [16:0]        q_r;
		logic [16:0]        q_g;
		logic [16:0]        q_b;
		logic signed [16:0] noise;
	} vgp_side_t;

endpackage

// ===== rtl/core/vgp_recip_div.sv =====
// Bit-serial restoring divider: round(2^24 / dim) for a frame dimension, one bit per cycle.
// Depends on vgp_pkg.
module vgp_recip_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] den,
	output logic        busy,
	output logic        done,
	output logic [24:0] quo
);

	logic [24:0] acc_q;
	logic [12:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] trial;
	logic        ge;

	assign trial = {rem_q, acc_q[24]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(vgp_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= vgp_pkg::RECIP_NUM + 25'(den >> 1);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 13'(trial - {1'b0, den}) : trial[12:0];
			acc_q <= {acc_q[23:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = acc_q;

endmodule

// ===== rtl/core/vgp_cfg.sv =====
// Register file behind the APB port, with frame size clamping and reciprocal updates.
// Depends on vgp_pkg and vgp_recip_div.
module vgp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output vgp_pkg::vgp_cfg_t cfg
);

	logic [7:0]  strength_q;
	logic [7:0]  grain_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [24:0] recip_x_q;
	logic [24:0] recip_y_q;
	logic        wr;
	vgp_pkg::reg_idx_t idx;
	logic        start_x, start_y;
	logic [12:0] dim_x, dim_y, wdim, den_x, den_y;
	logic        busy_x, busy_y, done_x, done_y;
	logic [24:0] quo_x, quo_y;

	function automatic logic [12:0] clamp_dim(input logic [12:0] d);
		logic [12:0] r;
		r = d;
		if (d == 13'd0) r = 13'd1;
		else if (d > vgp_pkg::DIM_MAX) r = vgp_pkg::DIM_MAX;
		return r;
	endfunction

	assign wr      = psel & penable & pwrite;
	assign idx     = vgp_pkg::reg_idx_t'(paddr[3:2]);
	assign start_x = wr && (idx == vgp_pkg::REG_WIDTH);
	assign start_y = wr && (idx == vgp_pkg::REG_HEIGHT);
	assign dim_x   = clamp_dim(width_q);
	assign dim_y   = clamp_dim(height_q);
	assign wdim    = clamp_dim(pwdata[12:0]);
	assign den_x   = start_x ? wdim : dim_x;
	assign den_y   = start_y ? wdim : dim_y;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= vgp_pkg::STRENGTH_RST;
			grain_q    <= vgp_pkg::GRAIN_RST;
			width_q    <= vgp_pkg::WIDTH_RST;
			height_q   <= vgp_pkg::HEIGHT_RST;
			recip_x_q  <= vgp_pkg::RECIP_X_RST;
			recip_y_q  <= vgp_pkg::RECIP_Y_RST;
		end else begin
			if (wr) begin
				case (idx)
					vgp_pkg::REG_STRENGTH: strength_q <= pwdata[7:0];
					vgp_pkg::REG_GRAIN:    grain_q    <= pwdata[7:0];
					vgp_pkg::REG_WIDTH:    width_q    <= pwdata[12:0];
					vgp_pkg::REG_HEIGHT:   height_q   <= pwdata[12:0];
					default: ;
				endcase
			end
			if (done_x) recip_x_q <= quo_x;
			if (done_y) recip_y_q <= quo_y;
		end
	end

	always_comb begin
		case (idx)
			vgp_pkg::REG_STRENGTH: prdata = {24'd0, strength_q};
			vgp_pkg::REG_GRAIN:    prdata = {24'd0, grain_q};
			vgp_pkg::REG_WIDTH:    prdata = {19'd0, width_q};
			vgp_pkg::REG_HEIGHT:   prdata = {19'd0, height_q};
			default:               prdata = '0;
		endcase
	end

	vgp_recip_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_x),
		.den    (den_x),
		.busy   (busy_x),
		.done   (done_x),
		.quo    (quo_x)
	);

	vgp_recip_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_y),
		.den    (den_y),
		.busy   (busy_y),
		.done   (done_y),
		.quo    (quo_y)
	);

	assign cfg.strength = strength_q;
	assign cfg.grain    = grain_q;
	assign cfg.dim_x    = dim_x;
	assign cfg.dim_y    = dim_y;
	assign cfg.recip_x  = recip_x_q;
	assign cfg.recip_y  = recip_y_q;
	assign cfg.busy     = busy_x | busy_y | done_x | done_y;

endmodule

// ===== rtl/core/vgp_isqrt.sv =====
// Pipelined integer square root, two result bits per stage, side data carried alongside.
// Depends on vgp_pkg.
module vgp_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic [35:0]        in_val,
	input  vgp_pkg::vgp_side_t in_side,
	output logic               out_vld,
	output logic [17:0]        out_root,
	output vgp_pkg::vgp_side_t out_side
);

	localparam int N = vgp_pkg::SQ_STAGES;

	logic [35:0]        rem_s  [N];
	logic [35:0]        root_s [N];
	vgp_pkg::vgp_side_t side_s [N];
	logic [N-1:0]       vld_s;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [35:0] v_c, r_c, v_in, r_in;

		if (k == 0) begin : g_first
			assign v_in = in_val;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = rem_s[k-1];
			assign r_in = root_s[k-1];
		end

		always_comb begin
			v_c = v_in;
			r_c = r_in;
			for (int j = 0; j < vgp_pkg::SQ_STEPS; j++) begin
				if (v_c >= r_c + (36'd1 << (34 - 2 * (vgp_pkg::SQ_STEPS * k + j)))) begin
					v_c = v_c - (r_c + (36'd1 << (34 - 2 * (vgp_pkg::SQ_STEPS * k + j))));
					r_c = (r_c >> 1) + (36'd1 << (34 - 2 * (vgp_pkg::SQ_STEPS * k + j)));
				end else begin
					r_c = r_c >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= v_c;
				root_s[k] <= r_c;
				side_s[k] <= (k == 0) ? in_side : side_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[N-2:0], in_vld};
		end
	end

	assign out_vld  = vld_s[N-1];
	assign out_root = root_s[N-1][17:0];
	assign out_side = side_s[N-1];

endmodule

// ===== rtl/core/vignette_grain_pixel_post.sv =====
// Vignette and grain post stage: takes one pixel per clock while pix_stall is low and returns
// one packed RGB item per pixel. A write to frame_width or frame_height starts a bit-serial
// reciprocal divider; pix_stall stays high until that divider's quotient has been stored.
// Depends on vgp_pkg, vgp_cfg, vgp_recip_div and vgp_isqrt.
module vignette_grain_pixel_post (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [11:0] x_pos,
	input  logic [11:0] y_pos,
	input  logic [11:0] red_in,
	input  logic [11:0] green_in,
	input  logic [11:0] blue_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [23:0] pixel_out
);

	vgp_pkg::vgp_cfg_t cfg;
	logic adv, take;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        vld_s15, vld_s16, vld_s17, vld_s18, vld_s19, vld_s20;
	logic        res_valid_q;
	logic [23:0] pix_q;

	logic [12:0] ax_s1, ay_s1;
	logic [31:0] n0_s1;
	logic [11:0] c_s1 [3];

	logic [37:0] mx_s2, my_s2;
	logic [31:0] n1_s2;
	logic [11:0] c_s2 [3];
	logic [16:0] q0_s2 [3];

	logic [17:0] fx_s3, fy_s3;
	logic        neg_s3;
	logic [23:0] mag_s3;
	logic [16:0] q_s3 [3];

	logic [35:0] fx2_s4, fy2_s4;
	logic [31:0] nm_s4;
	logic        neg_s4;
	logic [16:0] q_s4 [3];

	logic [35:0]        d2_s5;
	vgp_pkg::vgp_side_t side_s5;

	logic               vld_sq;
	logic [17:0]        root_sq;
	vgp_pkg::vgp_side_t side_sq;

	logic [32:0]        nt_s15;
	logic [16:0]        q0_s15;
	logic               lo_s15, hi_s15;
	vgp_pkg::vgp_side_t side_s15;

	logic [16:0]        t_s16;
	vgp_pkg::vgp_side_t side_s16;
	logic [16:0]        t_s17, t2_s17;
	vgp_pkg::vgp_side_t side_s17;
	logic [16:0]        s_s18;
	vgp_pkg::vgp_side_t side_s18;
	logic [16:0]        gain_s19;
	vgp_pkg::vgp_side_t side_s19;
	logic [16:0]        cg_s20 [3];
	logic signed [16:0] noise_s20;

	logic [12:0] two_x, two_y, ax_c, ay_c;
	logic [29:0] mxr_c, myr_c;
	logic [23:0] h_c;
	logic [24:0] twoh_c;
	logic [39:0] nn_c;
	logic [24:0] nsum_c;
	logic [15:0] qn_c;
	logic [17:0] nd_c;
	logic [64:0] tp_c;
	logic [33:0] trem_c;
	logic [16:0] q_in [3];
	logic [16:0] q_mid [3];
	logic [7:0]  o_c [3];

	vgp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv       = !res_valid_q || !res_stall;
	assign pix_stall = !adv || cfg.busy;
	assign take      = pix_valid && !pix_stall;

	assign two_x = {x_pos, 1'b0};
	assign two_y = {y_pos, 1'b0};
	assign ax_c  = (two_x >= cfg.dim_x) ? two_x - cfg.dim_x : cfg.dim_x - two_x;
	assign ay_c  = (two_y >= cfg.dim_y) ? two_y - cfg.dim_y : cfg.dim_y - two_y;
	assign mxr_c = 30'((mx_s2 + 38'd128) >> 8);
	assign myr_c = 30'((my_s2 + 38'd128) >> 8);
	assign h_c   = 24'(n1_s2 ^ (n1_s2 >> 16));
	assign twoh_c = {h_c, 1'b0};

	assign nn_c   = {1'b0, nm_s4, 7'd0} + 40'd8388607;
	assign nsum_c = 25'(nn_c[39:24]) + 25'(nn_c[23:0]);
	assign qn_c   = nn_c[39:24] + 16'(nsum_c >= 25'(vgp_pkg::NOISE_FULL));

	assign nd_c   = root_sq - vgp_pkg::EDGE_LO;
	assign tp_c   = 65'({nd_c[16:0], 16'd0} + 33'd36044) * 65'(vgp_pkg::SPAN_RECIP);
	assign trem_c = 34'(nt_s15) - 34'(q0_s15) * 34'(vgp_pkg::SPAN);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [28:0] nc;
			logic [29:0] rc;
			nc = {1'b0, c_s2[i], 16'd0} + 29'd2047;
			rc = 30'(nc) - (30'({q0_s2[i], 12'd0}) - 30'(q0_s2[i]));
			q_mid[i] = q0_s2[i] + 17'(rc >= 30'(vgp_pkg::CH_FULL));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [28:0] nc;
			logic [57:0] pc;
			nc = {1'b0, c_s1[i], 16'd0} + 29'd2047;
			pc = 58'(nc) * 58'(vgp_pkg::CH_RECIP);
			q_in[i] = pc[56:40];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [18:0] v;
			logic [16:0] vc;
			logic [24:0] w;
			v = $signed({2'b00, cg_s20[i]}) + 19'(noise_s20);
			if (v < 0) vc = '0;
			else if (v > $signed({2'b00, vgp_pkg::Q16_ONE})) vc = vgp_pkg::Q16_ONE;
			else vc = v[16:0];
			w = ({vc, 8'd0} - 25'(vc)) + 25'd32768;
			o_c[i] = w[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s15     <= 1'b0;
			vld_s16     <= 1'b0;
			vld_s17     <= 1'b0;
			vld_s18     <= 1'b0;
			vld_s19     <= 1'b0;
			vld_s20     <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= take;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s15     <= vld_sq;
			vld_s16     <= vld_s15;
			vld_s17     <= vld_s16;
			vld_s18     <= vld_s17;
			vld_s19     <= vld_s18;
			vld_s20     <= vld_s19;
			res_valid_q <= vld_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			n0_s1   <= 32'({20'd0, x_pos} * vgp_pkg::HASH_KX)
				^ 32'({20'd0, y_pos} * vgp_pkg::HASH_KY) ^ vgp_pkg::NOISE_MIX;
			c_s1[0] <= red_in;
			c_s1[1] <= green_in;
			c_s1[2] <= blue_in;

			mx_s2 <= 38'(ax_s1) * 38'(cfg.recip_x);
			my_s2 <= 38'(ay_s1) * 38'(cfg.recip_y);
			n1_s2 <= 32'((n0_s1 ^ (n0_s1 >> 13)) * vgp_pkg::HASH_KM);

			fx_s3  <= (mxr_c > 30'(vgp_pkg::COORD_SAT)) ? vgp_pkg::COORD_SAT : mxr_c[17:0];
			fy_s3  <= (myr_c > 30'(vgp_pkg::COORD_SAT)) ? vgp_pkg::COORD_SAT : myr_c[17:0];
			neg_s3 <= twoh_c < 25'(vgp_pkg::NOISE_FULL);
			mag_s3 <= (twoh_c < 25'(vgp_pkg::NOISE_FULL))
				? 24'(25'(vgp_pkg::NOISE_FULL) - twoh_c)
				: 24'(twoh_c - 25'(vgp_pkg::NOISE_FULL));

			fx2_s4 <= 36'(fx_s3) * 36'(fx_s3);
			fy2_s4 <= 36'(fy_s3) * 36'(fy_s3);
			nm_s4  <= 32'(mag_s3) * 32'(cfg.grain);
			neg_s4 <= neg_s3;

			d2_s5         <= 36'((52'(fx2_s4) * 52'(vgp_pkg::ELLIPSE_K)) >> 16) + fy2_s4;
			side_s5.q_r   <= q_s4[0];
			side_s5.q_g   <= q_s4[1];
			side_s5.q_b   <= q_s4[2];
			side_s5.noise <= neg_s4 ? -$signed({1'b0, qn_c}) : $signed({1'b0, qn_c});

			nt_s15   <= {nd_c[16:0], 16'd0} + 33'd36044;
			q0_s15   <= tp_c[64:48];
			lo_s15   <= root_sq <= vgp_pkg::EDGE_LO;
			hi_s15   <= root_sq >= vgp_pkg::EDGE_HI;
			side_s15 <= side_sq;

			if (lo_s15) t_s16 <= '0;
			else if (hi_s15) t_s16 <= vgp_pkg::Q16_ONE;
			else t_s16 <= q0_s15 + 17'(trem_c >= 34'(vgp_pkg::SPAN));
			side_s16 <= side_s15;

			t_s17    <= t_s16;
			t2_s17   <= 17'((34'(t_s16) * 34'(t_s16) + 34'd32768) >> 16);
			side_s17 <= side_s16;

			s_s18    <= 17'((35'(t2_s17) * 35'(18'd196608 - {t_s17, 1'b0})
				+ 35'd32768) >> 16);
			side_s18 <= side_s17;

			gain_s19 <= vgp_pkg::Q16_ONE
				- 17'((25'(cfg.strength) * 25'(s_s18) + 25'd128) >> 8);
			side_s19 <= side_s18;

			cg_s20[0] <= 17'((34'(side_s19.q_r) * 34'(gain_s19) + 34'd32768) >> 16);
			cg_s20[1] <= 17'((34'(side_s19.q_g) * 34'(gain_s19) + 34'd32768) >> 16);
			cg_s20[2] <= 17'((34'(side_s19.q_b) * 34'(gain_s19) + 34'd32768) >> 16);
			noise_s20 <= side_s19.noise;

			pix_q <= {o_c[0], o_c[1], o_c[2]};

			for (int i = 0; i < 3; i++) begin
				c_s2[i]  <= c_s1[i];
				q0_s2[i] <= q_in[i];
				q_s3[i]  <= q_mid[i];
				q_s4[i]  <= q_s3[i];
			end
		end
	end

	vgp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s5),
		.in_val   (d2_s5),
		.in_side  (side_s5),
		.out_vld  (vld_sq),
		.out_root (root_sq),
		.out_side (side_sq)
	);

	assign res_valid = res_valid_q;
	assign pixel_out = pix_q;

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && cfg.busy) |-> pix_stall)
		else $error("item taken while reciprocal update in flight");

	a_hold_all: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> ($stable(vld_s15) && $stable(vld_s20)
			&& $stable(t_s16) && $stable(gain_s19)))
		else $error("pipeline moved while output stalled");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s16 |-> (t_s16 <= vgp_pkg::Q16_ONE))
		else $error("smoothstep parameter out of range");

	a_gain_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s19 |-> (gain_s19 >= 17'd256))
		else $error("vignette gain below floor");

	a_coord_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (fx_s3 <= vgp_pkg::COORD_SAT && fy_s3 <= vgp_pkg::COORD_SAT))
		else $error("normalised coordinate beyond saturation");

endmodule
